// ===== rtl/core/gas_sensor_reply_checker_core_assert.svh =====
// Assertion macros for the gas sensor reply checker core.
// Used by the top level; needs no other file.
`ifndef GAS_SENSOR_REPLY_CHECKER_CORE_ASSERT_SVH
`define GAS_SENSOR_REPLY_CHECKER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GSRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define GSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/gsrc_pkg.sv =====
// Shared constants and codes for the gas sensor reply checker.
// No dependencies.
`default_nettype none

package gsrc_pkg;

  localparam int unsigned WORDS_PER_REPLY = 2;
  localparam int unsigned EMIT_FULL       = (WORDS_PER_REPLY < 2) ? 1 : 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_VARIANT_C3 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE   = 1'd1;

  localparam logic [1:0] Q_ECO2    = 2'd0;
  localparam logic [1:0] Q_TVOC    = 2'd1;
  localparam logic [1:0] Q_RAW_H2  = 2'd2;
  localparam logic [1:0] Q_RAW_ETH = 2'd3;

  localparam logic [1:0] STS_OK = 2'd0;

  localparam logic [1:0] POS_HIGH = 2'd0;
  localparam logic [1:0] POS_LOW  = 2'd1;
  localparam logic [1:0] POS_CRC  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/gsrc_crc8.sv =====
// One-byte update of the CRC-8 (poly 0x31, MSB first), unrolled XOR network.
// Depends on gsrc_pkg.
`default_nettype none

module gsrc_crc8 (
  input  wire logic [7:0] crc_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] crc_o
);
  import gsrc_pkg::*;

  always_comb begin
    logic [7:0] v;
    v = crc_i ^ byte_i;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'h00) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    crc_o = v;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gas_sensor_reply_checker_core.sv =====
// Top level of the gas sensor reply checker: input register, word/CRC tracking,
// result register. Depends on gsrc_pkg, gsrc_crc8 and the assertion header.
//
// Takes one reply byte per cycle through an input register; every third byte of a
// group closes a 16-bit word, checks its CRC-8 and, for groups that carry a quantity,
// loads one result into the output register as that byte leaves the input register.
// The sustained rate is one byte per clock, set by the combinational CRC byte update
// between the input register and the reply state. A held result only stalls the
// input once the input register also holds a byte that produces a result.
`default_nettype none

`include "gas_sensor_reply_checker_core_assert.svh"

module gas_sensor_reply_checker_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gsrc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gsrc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // byte input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [7:0]                       rx_byte_i,
  input  wire logic                             frame_start_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [15:0]                           word_value_o,
  output logic [1:0]                            quantity_o,
  output logic                                  crc_ok_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);
  import gsrc_pkg::*;

  // configuration registers
  logic variant_c3_q, raw_mode_q;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;

  // reply state
  logic [1:0] pos_q, pos_d;
  logic [1:0] wn_q, wn_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic [1:0] sts_q, sts_d;
  logic       done_q, done_d;

  // result register
  logic        out_valid_q;
  logic [15:0] word_q;
  logic [1:0]  qty_q, qty_d;
  logic        ok_q, ok_d;
  logic        last_q, last_d;
  logic [1:0]  sts_out_q;

  logic [1:0] pos_e, wn_e, sts_e;
  logic [7:0] crc_e, crc_new;
  logic       done_e;
  logic       emit, adv, out_free;
  logic [2:0] wn_next, emit_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_c3_q <= 1'b0;
      raw_mode_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VARIANT_C3: variant_c3_q <= cfg_data_i[0];
        REG_RAW_MODE:   raw_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // state as seen after frame_start clearing
  assign pos_e  = start_q ? POS_HIGH : pos_q;
  assign wn_e   = start_q ? 2'd0     : wn_q;
  assign crc_e  = start_q ? CRC_INIT : crc_q;
  assign sts_e  = start_q ? STS_OK   : sts_q;
  assign done_e = start_q ? 1'b0     : done_q;

  gsrc_crc8 u_crc8 (
    .crc_i  (crc_e),
    .byte_i (byte_q),
    .crc_o  (crc_new)
  );

  assign wn_next  = {1'b0, wn_e} + 3'd1;
  assign emit_cnt = (raw_mode_q || !variant_c3_q) ? 3'(EMIT_FULL) : 3'd1;

  always_comb begin
    pos_d  = pos_e;
    wn_d   = wn_e;
    crc_d  = crc_e;
    high_d = high_q;
    low_d  = low_q;
    sts_d  = sts_e;
    done_d = done_e;
    emit   = 1'b0;
    ok_d   = 1'b0;
    qty_d  = Q_ECO2;
    last_d = 1'b0;
    if (!done_e) begin
      case (pos_e)
        POS_HIGH: begin
          high_d = byte_q;
          crc_d  = crc_new;
          pos_d  = POS_LOW;
        end
        POS_LOW: begin
          low_d = byte_q;
          crc_d = crc_new;
          pos_d = POS_CRC;
        end
        default: begin
          ok_d  = (byte_q == crc_e);
          pos_d = POS_HIGH;
          crc_d = CRC_INIT;
          if (wn_next >= 3'(WORDS_PER_REPLY)) begin
            done_d = 1'b1;
          end else begin
            wn_d = wn_next[1:0];
          end
          emit = ({1'b0, wn_e} < emit_cnt);
          if (raw_mode_q) begin
            qty_d = (wn_e == 2'd0) ? Q_RAW_H2 : Q_RAW_ETH;
          end else if (variant_c3_q) begin
            qty_d = Q_TVOC;
          end else begin
            qty_d = (wn_e == 2'd0) ? Q_ECO2 : Q_TVOC;
          end
          if (emit && !ok_d && sts_e == STS_OK) begin
            sts_d = wn_next[1:0];
          end
          last_d = (wn_next == emit_cnt);
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HIGH;
      wn_q   <= 2'd0;
      crc_q  <= CRC_INIT;
      high_q <= 8'h00;
      low_q  <= 8'h00;
      sts_q  <= STS_OK;
      done_q <= 1'b0;
    end else if (adv) begin
      pos_q  <= pos_d;
      wn_q   <= wn_d;
      crc_q  <= crc_d;
      high_q <= high_d;
      low_q  <= low_d;
      sts_q  <= sts_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && emit) begin
      word_q    <= {high_q, low_q};
      qty_q     <= qty_d;
      ok_q      <= ok_d;
      last_q    <= last_d;
      sts_out_q <= sts_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_value_o = word_q;
  assign quantity_o   = qty_q;
  assign crc_ok_o     = ok_q;
  assign status_o     = sts_out_q;
  assign last_o       = last_q;

  `GSRC_ASSERT_IMPL(a_fail_sets_status, clk_i, rst_ni,
                    out_valid_o && !crc_ok_o, status_o != STS_OK)
  `GSRC_ASSERT_IMPL(a_ethanol_is_last, clk_i, rst_ni,
                    out_valid_o && quantity_o == Q_RAW_ETH, last_o)
  `GSRC_ASSERT_IMPL(a_done_at_group_start, clk_i, rst_ni,
                    done_q, pos_q == POS_HIGH)
  `GSRC_ASSERT_NEXT(a_result_needs_byte, clk_i, rst_ni,
                    !in_valid_q && !out_valid_q, !out_valid_q)

endmodule

`default_nettype wire

// ===== test/tb_gas_sensor_reply_checker_core.sv =====
// Self-checking testbench for gas_sensor_reply_checker_core: reply bytes are sent through a
// queue-fed driver, results are checked by a monitor against an in-bench CRC-8 word predictor.
// Depends on gsrc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_gas_sensor_reply_checker_core;
  import gsrc_pkg::*;

  localparam int         DRAIN_CYCLES = 8;
  localparam int         ITEMS_PER_PH = 132;
  localparam int         NUM_PHASES   = 8;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  typedef struct {
    logic [15:0] word;
    logic [1:0]  qty;
    logic        ok;
    logic [1:0]  sts;
    logic        last;
  } reply_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready_o;

  logic       in_valid    = 1'b0;
  logic [7:0] rx_byte     = 8'h00;
  logic       frame_start = 1'b0;
  logic       in_stall_o;

  logic        out_stall = 1'b0;
  logic        out_valid_o;
  logic [15:0] word_value_o;
  logic [1:0]  quantity_o;
  logic        crc_ok_o;
  logic [1:0]  status_o;
  logic        last_o;

  rx_item_t    pending_bytes[$];
  reply_word_t expected_words[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatches      = 0;
  int unsigned items_made      = 0;

  // predictor state and register mirror
  logic        cfg_c3   = 1'b0;
  logic        cfg_raw  = 1'b0;
  logic [1:0]  pred_pos = POS_HIGH;
  int unsigned pred_wnum = 0;
  logic [7:0]  pred_crc = CRC_INIT;
  logic [7:0]  pred_hi  = 8'h00;
  logic [7:0]  pred_lo  = 8'h00;
  logic [1:0]  pred_sts = STS_OK;
  bit          pred_done = 1'b0;

  gas_sensor_reply_checker_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .word_value_o  (word_value_o),
    .quantity_o    (quantity_o),
    .crc_ok_o      (crc_ok_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'h00) v = (v << 1) ^ CRC_POLY;
      else v = v << 1;
    end
    return v;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  task automatic predict_reply_byte(input logic [7:0] b, input logic fs);
    reply_word_t r;
    int unsigned emit_n;
    int unsigned w;
    logic        ok;
    if (fs) begin
      pred_pos  = POS_HIGH;
      pred_wnum = 0;
      pred_crc  = CRC_INIT;
      pred_sts  = STS_OK;
      pred_done = 1'b0;
    end
    if (pred_done) return;
    case (pred_pos)
      POS_HIGH: begin
        pred_hi  = b;
        pred_crc = crc8_next(CRC_INIT, b);
        pred_pos = POS_LOW;
      end
      POS_LOW: begin
        pred_lo  = b;
        pred_crc = crc8_next(pred_crc, b);
        pred_pos = POS_CRC;
      end
      default: begin
        ok       = (b == pred_crc);
        w        = pred_wnum;
        pred_pos = POS_HIGH;
        pred_crc = CRC_INIT;
        if (pred_wnum + 1 >= WORDS_PER_REPLY) pred_done = 1'b1;
        else pred_wnum = pred_wnum + 1;
        emit_n = (cfg_raw || !cfg_c3) ? EMIT_FULL : 1;
        if (w < emit_n) begin
          if (cfg_raw) r.qty = (w == 0) ? Q_RAW_H2 : Q_RAW_ETH;
          else if (cfg_c3) r.qty = Q_TVOC;
          else r.qty = (w == 0) ? Q_ECO2 : Q_TVOC;
          if (!ok && pred_sts == STS_OK) pred_sts = 2'(w + 1);
          r.word = {pred_hi, pred_lo};
          r.ok   = ok;
          r.sts  = pred_sts;
          r.last = (w + 1 == emit_n);
          expected_words.push_back(r);
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // byte driver
  always @(posedge clk) begin
    rx_item_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall_o) predict_reply_byte(rx_byte, frame_start);
      if (!in_valid || !in_stall_o) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid    <= 1'b1;
          rx_byte     <= nxt.data;
          frame_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_word_t e;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("unexpected result word=%h qty=%0d ok=%b sts=%0d last=%b",
                                  word_value_o, quantity_o, crc_ok_o, status_o, last_o));
        end else begin
          e = expected_words.pop_front();
          if (word_value_o !== e.word || quantity_o !== e.qty || crc_ok_o !== e.ok ||
              status_o !== e.sts || last_o !== e.last) begin
            note_mismatch($sformatf(
              "exp word=%h qty=%0d ok=%b sts=%0d last=%b, got word=%h qty=%0d ok=%b sts=%0d last=%b",
              e.word, e.qty, e.ok, e.sts, e.last,
              word_value_o, quantity_o, crc_ok_o, status_o, last_o));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_VARIANT_C3) cfg_c3 = val[0];
    else cfg_raw = val[0];
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fs, input bit counts);
    pending_bytes.push_back('{b, fs});
    if (counts) items_made++;
  endtask

  task automatic queue_word(input logic [15:0] w, input logic fs, input logic [7:0] crc_flip);
    queue_byte(w[15:8], fs, 1'b1);
    queue_byte(w[7:0], 1'b0, 1'b1);
    queue_byte(word_crc(w) ^ crc_flip, 1'b0, 1'b1);
  endtask

  task automatic queue_random_reply();
    logic [7:0]  rb[0:3*WORDS_PER_REPLY-1];
    logic [15:0] w;
    logic        fs;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    fs   = ($urandom_range(9) != 0);
    for (int g = 0; g < WORDS_PER_REPLY; g++) begin
      case ($urandom_range(7))
        0: w = 16'h0000;
        1: w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      rb[3*g]   = w[15:8];
      rb[3*g+1] = w[7:0];
      rb[3*g+2] = word_crc(w) ^ (($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
    end
    if (kind < 70) begin
      for (int i = 0; i < 3 * WORDS_PER_REPLY; i++) queue_byte(rb[i], (i == 0) ? fs : 1'b0, 1'b1);
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom), 1'b0, 1'b0);
      end
    end else if (kind < 85) begin
      n = $urandom_range(1, 3 * WORDS_PER_REPLY - 1);
      for (int i = 0; i < n; i++) queue_byte(rb[i], (i == 0) ? fs : 1'b0, 1'b1);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom), ($urandom_range(3) == 0), 1'b1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  initial begin
    logic c3_sel;
    logic raw_sel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_VARIANT_C3, 1'b0);
    write_reg(REG_RAW_MODE, 1'b0);

    // first reply arrives with no frame_start after reset
    queue_word(16'hFFFF, 1'b0, 8'h00);
    queue_word(16'h0000, 1'b0, 8'h00);
    // bytes past the end of a reply are ignored
    queue_byte(8'hA5, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0);
    // both words fail; status keeps the first failure
    queue_word(16'h0000, 1'b1, 8'hFF);
    queue_word(16'hFFFF, 1'b0, 8'h01);
    // restart mid group, then only the second word fails
    queue_byte(8'h12, 1'b1, 1'b1);
    queue_byte(8'h34, 1'b0, 1'b1);
    queue_word(16'hBEEF, 1'b1, 8'h00);
    queue_word(16'h8001, 1'b0, 8'h80);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        c3_sel  = (p == 0 || p == 2);
        raw_sel = (p == 1 || p == 2);
        set_idling(p);
      end else begin
        c3_sel  = 1'($urandom);
        raw_sel = 1'($urandom);
        set_idling((p + 2) % 4);
      end
      write_reg(REG_VARIANT_C3, c3_sel);
      write_reg(REG_RAW_MODE, raw_sel);
      items_made = 0;
      while (items_made < ITEMS_PER_PH / 2) queue_random_reply();
      if (p == 1) begin
        // sender holds off until every pending result has come back
        @(negedge clk);
        while (pending_bytes.size() != 0 || expected_words.size() != 0) @(negedge clk);
      end
      while (items_made < ITEMS_PER_PH) queue_random_reply();
      wait_idle();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("gas_sensor_reply_checker_core test passed");
    end else begin
      $display("gas_sensor_reply_checker_core test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("gas_sensor_reply_checker_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gsrc_pkg.sv
rtl/core/gsrc_crc8.sv
rtl/core/gas_sensor_reply_checker_core.sv
test/tb_gas_sensor_reply_checker_core.sv
